>>> rtl/gn2d_pkg.sv
`timescale 1ns / 1ps

package gn2d_pkg;

  localparam logic [31:0] HASH_K1 = 32'd3284157443;
  localparam logic [31:0] HASH_K2 = 32'd1911520717;
  localparam logic [31:0] HASH_K3 = 32'd2048419325;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  typedef logic signed [17:0] grad_t;

  function automatic logic [31:0] rot_half(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // quarter-wave sine, r in units of 2*pi/65536, taylor series in q.30
  function automatic logic [16:0] qsin_f(input logic [31:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x    = (64'(r) * PI_Q30) >> 15;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    return 17'((sum + 64'sd8192) >>> 14);
  endfunction

endpackage

>>> rtl/gn2d_if.sv
`timescale 1ns / 1ps

interface gn2d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink   (input valid, input coord_x, input coord_y, output ready);
endinterface

interface gn2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

>>> rtl/gn2d_hash.sv
`timescale 1ns / 1ps

module gn2d_hash
  import gn2d_pkg::*;
#(
  parameter int PHASE_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [31:0]           cx_i,
  input  logic [31:0]           cy_i,
  output logic [PHASE_BITS-1:0] phase_o
);

  logic [31:0] a_d, a_q, cy_q;
  logic [31:0] b_d, b_q, a2_q;
  logic [31:0] h_d;
  logic [PHASE_BITS-1:0] phase_q;

  assign a_d = cx_i * HASH_K1;
  assign b_d = (cy_q ^ rot_half(a_q)) * HASH_K2;
  assign h_d = (a2_q ^ rot_half(b_q)) * HASH_K3;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q     <= a_d;
      cy_q    <= cy_i;
      b_q     <= b_d;
      a2_q    <= a_q;
      phase_q <= h_d[31 -: PHASE_BITS];
    end
  end

  assign phase_o = phase_q;

endmodule

>>> rtl/gradient_noise_2d.sv
`timescale 1ns / 1ps
// 2-d gradient noise, one sample point in, one noise value out
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined hash and blend datapath
// a stall at the output holds every stage in place
// reset clears the stage valid bits only; the datapath registers are not reset

module gradient_noise_2d
  import gn2d_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int PHASE_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gn2d_in_if.sink     in_i,
  gn2d_out_if.source  out_o
);

  localparam int NST = 11;
  localparam int QN  = 1 << (PHASE_BITS - 2);

  logic           en;
  logic [NST-1:0] v_q;

  assign en         = !v_q[NST-1] || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = v_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NST-2:0], in_i.valid};
    end
  end

  // quarter-wave sine table
  logic [16:0] qsin_tab [QN+1];
  for (genvar i = 0; i <= QN; i++) begin : g_tab
    assign qsin_tab[i] = qsin_f(32'(i) << (16 - PHASE_BITS));
  end

  // stage 1: cell and fraction
  logic [31:0] x0_q, x1_q, y0_q, y1_q;
  logic [15:0] fx1_q, fy1_q;
  logic [31:0] x0_d, y0_d;

  assign x0_d = 32'(in_i.coord_x >>> FRAC_BITS);
  assign y0_d = 32'(in_i.coord_y >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q  <= x0_d;
      x1_q  <= x0_d + 32'd1;
      y0_q  <= y0_d;
      y1_q  <= y0_d + 32'd1;
      fx1_q <= 16'({in_i.coord_x[FRAC_BITS-1:0], 16'd0} >> FRAC_BITS);
      fy1_q <= 16'({in_i.coord_y[FRAC_BITS-1:0], 16'd0} >> FRAC_BITS);
    end
  end

  // stages 2 to 4: corner hashes
  logic [PHASE_BITS-1:0] ph [4];

  gn2d_hash #(.PHASE_BITS(PHASE_BITS)) u_hash0 (
    .clk_i(clk_i), .en_i(en), .cx_i(x0_q), .cy_i(y0_q), .phase_o(ph[0]));
  gn2d_hash #(.PHASE_BITS(PHASE_BITS)) u_hash1 (
    .clk_i(clk_i), .en_i(en), .cx_i(x1_q), .cy_i(y0_q), .phase_o(ph[1]));
  gn2d_hash #(.PHASE_BITS(PHASE_BITS)) u_hash2 (
    .clk_i(clk_i), .en_i(en), .cx_i(x0_q), .cy_i(y1_q), .phase_o(ph[2]));
  gn2d_hash #(.PHASE_BITS(PHASE_BITS)) u_hash3 (
    .clk_i(clk_i), .en_i(en), .cx_i(x1_q), .cy_i(y1_q), .phase_o(ph[3]));

  // stages 2 to 4: smoothstep weights
  logic [15:0] fxd_q [3];
  logic [15:0] fyd_q [3];
  logic [31:0] wx2_q, wy2_q;
  logic [49:0] pxs_q, pys_q;
  logic [16:0] sx4_q, sy4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fxd_q[0] <= fx1_q;
      fyd_q[0] <= fy1_q;
      fxd_q[1] <= fxd_q[0];
      fyd_q[1] <= fyd_q[0];
      fxd_q[2] <= fxd_q[1];
      fyd_q[2] <= fyd_q[1];
      wx2_q <= 32'(fx1_q) * 32'(fx1_q);
      wy2_q <= 32'(fy1_q) * 32'(fy1_q);
      pxs_q <= 50'(wx2_q) * 50'(18'd196608 - {1'b0, fxd_q[0], 1'b0});
      pys_q <= 50'(wy2_q) * 50'(18'd196608 - {1'b0, fyd_q[0], 1'b0});
      sx4_q <= 17'((pxs_q + 50'h80000000) >> 32);
      sy4_q <= 17'((pys_q + 50'h80000000) >> 32);
    end
  end

  // stage 5: gradient lookup
  grad_t gx_d [4];
  grad_t gy_d [4];
  grad_t gx_q [4];
  grad_t gy_q [4];
  logic [15:0] fx5_q, fy5_q;
  logic [16:0] sx5_q, sy5_q;

  always_comb begin
    logic [PHASE_BITS-1:0] p;
    logic [PHASE_BITS-2:0] idx;
    for (int c = 0; c < 4; c++) begin
      p   = ph[c];
      idx = p[PHASE_BITS-2] ? (PHASE_BITS-1)'(QN) - {1'b0, p[PHASE_BITS-3:0]}
                            : {1'b0, p[PHASE_BITS-3:0]};
      gx_d[c] = p[PHASE_BITS-1] ? -$signed({1'b0, qsin_tab[idx]})
                                : $signed({1'b0, qsin_tab[idx]});
      p   = ph[c] + PHASE_BITS'(QN);
      idx = p[PHASE_BITS-2] ? (PHASE_BITS-1)'(QN) - {1'b0, p[PHASE_BITS-3:0]}
                            : {1'b0, p[PHASE_BITS-3:0]};
      gy_d[c] = p[PHASE_BITS-1] ? -$signed({1'b0, qsin_tab[idx]})
                                : $signed({1'b0, qsin_tab[idx]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gx_q  <= gx_d;
      gy_q  <= gy_d;
      fx5_q <= fxd_q[2];
      fy5_q <= fyd_q[2];
      sx5_q <= sx4_q;
      sy5_q <= sy4_q;
    end
  end

  // stage 6: dot product terms
  logic signed [17:0] dxl, dxr, dyl, dyr;
  logic signed [35:0] px_q [4];
  logic signed [35:0] py_q [4];
  logic [16:0] sx6_q, sy6_q;

  assign dxl = $signed({2'b00, fx5_q});
  assign dyl = $signed({2'b00, fy5_q});
  assign dxr = dxl - ONE_Q16;
  assign dyr = dyl - ONE_Q16;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q[0] <= dxl * gx_q[0];
      py_q[0] <= dyl * gy_q[0];
      px_q[1] <= dxr * gx_q[1];
      py_q[1] <= dyl * gy_q[1];
      px_q[2] <= dxl * gx_q[2];
      py_q[2] <= dyr * gy_q[2];
      px_q[3] <= dxr * gx_q[3];
      py_q[3] <= dyr * gy_q[3];
      sx6_q   <= sx5_q;
      sy6_q   <= sy5_q;
    end
  end

  // stage 7: rounded dot products
  logic signed [18:0] n_q [4];
  logic [16:0] sx7_q, sy7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        n_q[c] <= 19'((37'(px_q[c]) + 37'(py_q[c]) + 37'sd32768) >>> 16);
      end
      sx7_q <= sx6_q;
      sy7_q <= sy6_q;
    end
  end

  // stages 8 and 9: blend along x
  logic signed [37:0] tp_q, bp_q;
  logic signed [18:0] n0t_q, n0b_q;
  logic [16:0] sy8_q, sy9_q;
  logic signed [19:0] top_q, bot_q;
  logic signed [17:0] sxs;

  assign sxs = $signed({1'b0, sx7_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      tp_q  <= (20'(n_q[1]) - 20'(n_q[0])) * sxs;
      bp_q  <= (20'(n_q[3]) - 20'(n_q[2])) * sxs;
      n0t_q <= n_q[0];
      n0b_q <= n_q[2];
      sy8_q <= sy7_q;
      top_q <= 20'(n0t_q) + 20'((tp_q + 38'sd32768) >>> 16);
      bot_q <= 20'(n0b_q) + 20'((bp_q + 38'sd32768) >>> 16);
      sy9_q <= sy8_q;
    end
  end

  // stages 10 and 11: blend along y and saturate
  logic signed [38:0] vp_q;
  logic signed [19:0] top10_q;
  logic signed [20:0] v_d;
  logic signed [17:0] noise_q;

  assign v_d = 21'(top10_q) + 21'((vp_q + 39'sd32768) >>> 16);

  always_ff @(posedge clk_i) begin
    if (en) begin
      vp_q    <= (21'(bot_q) - 21'(top_q)) * $signed({1'b0, sy9_q});
      top10_q <= top_q;
      if (v_d > 21'sd65536) begin
        noise_q <= ONE_Q16;
      end else if (v_d < -21'sd65536) begin
        noise_q <= -ONE_Q16;
      end else begin
        noise_q <= 18'(v_d);
      end
    end
  end

  assign out_o.noise_value = noise_q;

endmodule

>>> verif/gn2d_test_if.sv
`timescale 1ns / 1ps

>>> verif/gradient_noise_2d_test.sv
`timescale 1ns / 1ps

module gradient_noise_2d_test
  import gn2d_pkg::*;
;

  localparam int FRAC_BITS  = 16;
  localparam int PHASE_BITS = 10;
  localparam int LATENCY    = 11;

  logic clk_i;
  logic rst_ni;
  logic hold_out;
  int   err_count;
  logic signed [17:0] noise_q[$];

  gn2d_in_if  in_ch();
  gn2d_out_if out_ch();

  gradient_noise_2d #(.FRAC_BITS(FRAC_BITS), .PHASE_BITS(PHASE_BITS)) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic logic [31:0] swap16(logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic [31:0] hash_phase(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] a;
    logic [31:0] b;
    a = cx * HASH_K1;
    b = cy ^ swap16(a);
    b = b * HASH_K2;
    a = a ^ swap16(b);
    a = a * HASH_K3;
    return a >> (32 - PHASE_BITS);
  endfunction

  function automatic longint quarter_wave(logic [31:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x = (64'(r) * 64'd3373259426) >> 15;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    return (acc + 8192) >>> 14;
  endfunction

  function automatic longint wave_sin(logic [31:0] u);
    logic [1:0]  q;
    logic [31:0] r;
    longint      v;
    q = u[15:14];
    r = {18'd0, u[13:0]};
    v = q[0] ? quarter_wave(32'd16384 - r) : quarter_wave(r);
    return q[1] ? -v : v;
  endfunction

  function automatic longint corner_dot(logic [31:0] cx, logic [31:0] cy,
                                       longint dx, longint dy);
    logic [31:0] u;
    u = hash_phase(cx, cy) << (16 - PHASE_BITS);
    return rnd16(dx * wave_sin(u) + dy * wave_sin(u + 32'd16384));
  endfunction

  function automatic longint fade(longint w);
    logic [63:0] uw;
    uw = 64'(w);
    return longint'(((uw * uw) * (64'd196608 - 2 * uw) + 64'h80000000) >> 32);
  endfunction

  function automatic longint lerp(longint a0, longint a1, longint s);
    return a0 + rnd16((a1 - a0) * s);
  endfunction

  function automatic logic signed [17:0] noise_at(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] x0;
    logic [31:0] y0;
    longint fx;
    longint fy;
    longint sx;
    longint sy;
    longint top;
    longint bot;
    longint v;
    x0 = 32'(floor_sh(longint'($signed(cx)), FRAC_BITS));
    y0 = 32'(floor_sh(longint'($signed(cy)), FRAC_BITS));
    fx = longint'(cx & ((32'd1 << FRAC_BITS) - 1));
    fy = longint'(cy & ((32'd1 << FRAC_BITS) - 1));
    if (FRAC_BITS >= 16) begin
      fx = fx >> (FRAC_BITS - 16);
      fy = fy >> (FRAC_BITS - 16);
    end else begin
      fx = fx << (16 - FRAC_BITS);
      fy = fy << (16 - FRAC_BITS);
    end
    sx = fade(fx);
    sy = fade(fy);
    top = lerp(corner_dot(x0, y0, fx, fy), corner_dot(x0 + 1, y0, fx - 65536, fy), sx);
    bot = lerp(corner_dot(x0, y0 + 1, fx, fy - 65536),
               corner_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), sx);
    v = lerp(top, bot, sy);
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return 18'(v);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 30);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  task automatic report(string what, logic signed [17:0] got, logic signed [17:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic send_point(logic [31:0] cx, logic [31:0] cy);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    noise_q.push_back(noise_at(cx, cy));
    in_ch.valid   <= 1'b1;
    in_ch.coord_x <= cx;
    in_ch.coord_y <= cy;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (noise_q.size() == 0) begin
        report("unexpected item", out_ch.noise_value, 18'sd0);
      end else begin
        logic signed [17:0] want;
        want = noise_q.pop_front();
        if (out_ch.noise_value !== want) report("noise_value", out_ch.noise_value, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_out) out_ch.ready <= 1'b0;
    else if ($urandom_range(0, 3) == 0) out_ch.ready <= ($urandom_range(0, 9) == 0);
    else out_ch.ready <= 1'b1;
  end

  task automatic test_corners();
    logic [31:0] vals[8];
    vals = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF,
             32'h0000FFFF, 32'hFFFF0000, 32'h00010000, 32'h7FFF8000};
    for (int i = 0; i < 8; i++) send_point(vals[i], vals[(i * 3 + 1) % 8]);
    send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_point(32'h80000000, 32'h80000000);
    send_point(32'hFFFFFFFF, 32'h00000000);
    send_point(32'h00008000, 32'h00008000);
  endtask

  task automatic test_backpressure();
    hold_out <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_out <= 1'b0;
      end
      for (int i = 0; i < 30; i++) send_point($urandom, $urandom);
    join
  endtask

  task automatic test_random();
    logic [31:0] cx;
    logic [31:0] cy;
    for (int i = 0; i < 400; i++) begin
      cx = $urandom;
      cy = $urandom;
      if ($urandom_range(0, 3) == 0) begin
        cx = {16'($urandom_range(0, 7) - 4), 16'h0} | (cx & 32'hFFFF);
        cy = {16'($urandom_range(0, 7) - 4), 16'h0} | (cy & 32'hFFFF);
      end
      send_point(cx, cy);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    hold_out = 1'b0;
    err_count = 0;
    in_ch.valid = 1'b0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_backpressure();
    test_random();
    in_ch.valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (err_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
